[hw/rtl/ipcs_pkg.sv]
package ipcs_pkg;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] ip_checksum;
    logic [15:0] l4_checksum;
    logic [1:0]  l4_kind;
    logic [15:0] l4_field_offset;
    logic        malformed;
  } out_beat_t;

  // per-packet totals handed from the accumulator to the fold stage
  typedef struct packed {
    logic [31:0] header_sum;
    logic [31:0] payload_sum;
    logic [3:0]  header_words;
    logic [15:0] total_length;
    logic [7:0]  protocol_number;
    logic [16:0] byte_count;
  } pkt_sum_t;

  localparam logic [15:0] POS_IHL          = 16'd0;
  localparam logic [15:0] POS_TLEN_HI      = 16'd2;
  localparam logic [15:0] POS_TLEN_LO      = 16'd3;
  localparam logic [15:0] POS_PROTO        = 16'd9;
  localparam logic [15:0] POS_CSUM_HI      = 16'd10;
  localparam logic [15:0] POS_CSUM_LO      = 16'd11;
  localparam logic [15:0] POS_PSEUDO_FIRST = 16'd12;
  localparam logic [15:0] POS_PSEUDO_LAST  = 16'd19;
  localparam logic [15:0] POS_MAX          = 16'hffff;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_ICMP  = 2'd1;
  localparam logic [1:0] KIND_TCP   = 2'd2;
  localparam logic [1:0] KIND_UDP   = 2'd3;

  localparam logic [4:0] OFF_ICMP = 5'd2;
  localparam logic [4:0] OFF_TCP  = 5'd16;
  localparam logic [4:0] OFF_UDP  = 5'd6;

  localparam logic [3:0] MIN_IHL = 4'd5;

  function automatic logic [1:0] kind_of(input logic [7:0] prot);
    logic [1:0] k;
    k = KIND_OTHER;
    if (prot == PROTO_ICMP) k = KIND_ICMP;
    else if (prot == PROTO_TCP) k = KIND_TCP;
    else if (prot == PROTO_UDP) k = KIND_UDP;
    return k;
  endfunction

  function automatic logic [4:0] csum_offset(input logic [1:0] kind);
    logic [4:0] o;
    unique case (kind)
      KIND_ICMP: o = OFF_ICMP;
      KIND_TCP:  o = OFF_TCP;
      KIND_UDP:  o = OFF_UDP;
      default:   o = 5'd0;
    endcase
    return o;
  endfunction

  // end-around carry fold of a 32-bit sum; two passes always suffice
  function automatic logic [15:0] fold16(input logic [31:0] s);
    logic [16:0] f1;
    logic [15:0] f2;
    f1 = {1'b0, s[31:16]} + {1'b0, s[15:0]};
    f2 = f1[15:0] + {15'd0, f1[16]};
    return f2;
  endfunction

endpackage

[hw/rtl/ipcs_acc.sv]
module ipcs_acc (
  input  logic              clk,
  input  logic              rst,
  input  logic              pkt_valid,
  output logic              pkt_ready,
  input  ipcs_pkg::in_beat_t pkt,
  output logic              sum_valid,
  input  logic              sum_ready,
  output ipcs_pkg::pkt_sum_t sum
);

  logic [15:0] byte_position;
  logic [3:0]  header_words;
  logic [15:0] total_length;
  logic [7:0]  protocol_number;
  logic [31:0] header_sum;
  logic [31:0] payload_sum;

  logic [15:0] byte_position_next;
  logic [3:0]  header_words_next;
  logic [15:0] total_length_next;
  logic [7:0]  protocol_number_next;
  logic [31:0] header_sum_next;
  logic [31:0] payload_sum_next;

  logic [15:0] w;
  logic [5:0]  hlen;
  logic [1:0]  kind;
  logic [15:0] fpos;
  logic        hdr_add;
  logic        pseudo_add;
  logic        seg_add;
  logic        skip;
  logic [16:0] pay_addend;
  logic        accept;

  assign pkt_ready = !sum_valid || sum_ready;
  assign accept    = pkt_valid && pkt_ready;

  always_comb begin
    w = byte_position[0] ? {8'd0, pkt.packet_byte} : {pkt.packet_byte, 8'd0};

    header_words_next    = header_words;
    total_length_next    = total_length;
    protocol_number_next = protocol_number;
    if (byte_position == ipcs_pkg::POS_IHL) begin
      header_words_next = pkt.packet_byte[3:0];
    end else if (byte_position == ipcs_pkg::POS_TLEN_HI) begin
      total_length_next = {pkt.packet_byte, total_length[7:0]};
    end else if (byte_position == ipcs_pkg::POS_TLEN_LO) begin
      total_length_next = {total_length[15:8], pkt.packet_byte};
    end else if (byte_position == ipcs_pkg::POS_PROTO) begin
      protocol_number_next = pkt.packet_byte;
    end

    hlen = {header_words_next, 2'b00};
    kind = ipcs_pkg::kind_of(protocol_number_next);
    fpos = {10'd0, hlen} + {11'd0, ipcs_pkg::csum_offset(kind)};

    hdr_add = (byte_position < {10'd0, hlen}) &&
              (byte_position != ipcs_pkg::POS_CSUM_HI) &&
              (byte_position != ipcs_pkg::POS_CSUM_LO);
    pseudo_add = (byte_position >= ipcs_pkg::POS_PSEUDO_FIRST) &&
                 (byte_position <= ipcs_pkg::POS_PSEUDO_LAST) &&
                 ((kind == ipcs_pkg::KIND_TCP) || (kind == ipcs_pkg::KIND_UDP));
    skip = (kind != ipcs_pkg::KIND_OTHER) &&
           ((byte_position == fpos) || (byte_position == fpos + 16'd1));
    seg_add = (byte_position >= {10'd0, hlen}) &&
              (byte_position < total_length_next) && !skip;

    unique case ({pseudo_add, seg_add})
      2'b11:   pay_addend = {w, 1'b0};
      2'b10,
      2'b01:   pay_addend = {1'b0, w};
      default: pay_addend = 17'd0;
    endcase

    header_sum_next  = header_sum + (hdr_add ? {16'd0, w} : 32'd0);
    payload_sum_next = payload_sum + {15'd0, pay_addend};
    byte_position_next = (byte_position == ipcs_pkg::POS_MAX) ?
                         byte_position : byte_position + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      header_words    <= '0;
      total_length    <= '0;
      protocol_number <= '0;
      header_sum      <= '0;
      payload_sum     <= '0;
    end else if (accept) begin
      if (pkt.last_byte) begin
        byte_position   <= '0;
        header_words    <= '0;
        total_length    <= '0;
        protocol_number <= '0;
        header_sum      <= '0;
        payload_sum     <= '0;
      end else begin
        byte_position   <= byte_position_next;
        header_words    <= header_words_next;
        total_length    <= total_length_next;
        protocol_number <= protocol_number_next;
        header_sum      <= header_sum_next;
        payload_sum     <= payload_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (accept && pkt.last_byte) begin
      sum_valid <= 1'b1;
    end else if (sum_ready) begin
      sum_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pkt.last_byte) begin
      sum.header_sum      <= header_sum_next;
      sum.payload_sum     <= payload_sum_next;
      sum.header_words    <= header_words_next;
      sum.total_length    <= total_length_next;
      sum.protocol_number <= protocol_number_next;
      sum.byte_count      <= {1'b0, byte_position} + 17'd1;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && pkt.last_byte |=> sum_valid && byte_position == '0 && header_sum == '0)
    else $error("state not cleared after last beat");

  a_mid_keeps_sum: assert property (@(posedge clk) disable iff (rst)
    sum_valid && !sum_ready |=> sum_valid && $stable(sum))
    else $error("pending packet totals lost");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !sum_valid)
    else $error("totals valid after reset");

endmodule

[hw/rtl/ipcs_fold.sv]
module ipcs_fold (
  input  logic               clk,
  input  logic               rst,
  input  logic               sum_valid,
  output logic               sum_ready,
  input  ipcs_pkg::pkt_sum_t sum,
  output logic               res_valid,
  input  logic               res_ready,
  output ipcs_pkg::out_beat_t res
);

  logic [5:0]  hlen;
  logic [1:0]  kind;
  logic [15:0] l4_len;
  logic [31:0] l4_sum;
  logic [15:0] l4c;
  logic        bad;
  ipcs_pkg::out_beat_t res_next;

  assign sum_ready = !res_valid || res_ready;

  always_comb begin
    hlen   = {sum.header_words, 2'b00};
    kind   = ipcs_pkg::kind_of(sum.protocol_number);
    l4_len = sum.total_length - {10'd0, hlen};
    l4_sum = sum.payload_sum;
    if ((kind == ipcs_pkg::KIND_TCP) || (kind == ipcs_pkg::KIND_UDP)) begin
      l4_sum = sum.payload_sum + {24'd0, sum.protocol_number} + {16'd0, l4_len};
    end
    l4c = ~ipcs_pkg::fold16(l4_sum);
    if ((kind == ipcs_pkg::KIND_UDP) && (l4c == 16'd0)) begin
      l4c = 16'hffff;
    end
    bad = (sum.header_words < ipcs_pkg::MIN_IHL) ||
          (sum.byte_count < {1'b0, sum.total_length}) ||
          (sum.byte_count < {11'd0, hlen}) ||
          (sum.total_length < {10'd0, hlen});

    res_next.ip_checksum = ~ipcs_pkg::fold16(sum.header_sum);
    res_next.l4_kind     = kind;
    res_next.malformed   = bad;
    if (kind == ipcs_pkg::KIND_OTHER) begin
      res_next.l4_checksum     = 16'd0;
      res_next.l4_field_offset = 16'd0;
    end else begin
      res_next.l4_checksum     = l4c;
      res_next.l4_field_offset = {10'd0, hlen} + {11'd0, ipcs_pkg::csum_offset(kind)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (sum_ready) begin
      res_valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_valid && sum_ready) begin
      res <= res_next;
    end
  end

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  a_other_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.l4_kind == ipcs_pkg::KIND_OTHER |->
      res.l4_checksum == 16'd0 && res.l4_field_offset == 16'd0)
    else $error("L4 fields set for non-L4 protocol");

  a_udp_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.l4_kind == ipcs_pkg::KIND_UDP |-> res.l4_checksum != 16'd0)
    else $error("UDP checksum sent as zero");

  a_handoff: assert property (@(posedge clk) disable iff (rst)
    sum_valid && sum_ready |=> res_valid)
    else $error("packet totals dropped at fold stage");

endmodule

[hw/rtl/ipv4_l4_checksum_engine_top.sv]
// channel  | valid      | ready      | beat
// ---------+------------+------------+--------------------------------------
// pkt      | pkt_valid  | pkt_ready  | in_beat_t: one packet byte + last mark
// res      | res_valid  | res_ready  | out_beat_t: checksums, kind, offset, malformed
//
// One byte accepted per cycle while pkt_ready is high; the running sums take one add per byte.
// After its last byte a result is registered in the totals register, then in the fold register.
// Reset (rst, synchronous) clears packet state and both valid flags.
// A stalled result holds the fold register; bytes keep flowing until the
// totals register also holds a packet waiting behind it.
module ipv4_l4_checksum_engine_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                pkt_valid,
  output logic                pkt_ready,
  input  ipcs_pkg::in_beat_t  pkt,
  output logic                res_valid,
  input  logic                res_ready,
  output ipcs_pkg::out_beat_t res
);

  logic               sum_valid;
  logic               sum_ready;
  ipcs_pkg::pkt_sum_t sum;

  ipcs_acc u_acc (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .pkt       (pkt),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum       (sum)
  );

  ipcs_fold u_fold (
    .clk       (clk),
    .rst       (rst),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum       (sum),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule
